[rtl/core/lidar_express_packet_parser_macros.svh]
// Assertion macros for the express packet parser RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef LIDAR_EXPRESS_PACKET_PARSER_MACROS_SVH
`define LIDAR_EXPRESS_PACKET_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LEP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define LEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lep_pkg.sv]
// Package for the express packet parser: constants and the result record.
// No dependencies; used by lep_parse, lep_out_reg and the top level.
`default_nettype none

package lep_pkg;

  // Upper nibbles of the two sync bytes.
  localparam logic [3:0] SYNC1_NIB = 4'hA;
  localparam logic [3:0] SYNC2_NIB = 4'h5;

  // Cabins per packet (default) and bytes per cabin.
  localparam int unsigned CABINS_DEF  = 16;
  localparam int unsigned CABIN_BYTES = 5;

  // Byte position of the last byte of a cabin.
  localparam logic [2:0] LAST_POS = 3'(CABIN_BYTES - 1);

  typedef struct packed {
    logic [3:0]  cabin_index;
    logic        packet_end;
    logic        checksum_ok;
    logic [14:0] start_angle;
    logic        new_scan;
    logic [13:0] distance_first;
    logic [5:0]  angle_comp_first;
    logic [13:0] distance_second;
    logic [5:0]  angle_comp_second;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/lep_if.sv]
// Channel interfaces of the express packet parser: received bytes in,
// decoded cabins out. Valid/ready handshake; no package dependency.
`default_nettype none

interface lep_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lep_cabin_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cabin_index;
  logic        packet_end;
  logic        checksum_ok;
  logic [14:0] start_angle;
  logic        new_scan;
  logic [13:0] distance_first;
  logic [5:0]  angle_comp_first;
  logic [13:0] distance_second;
  logic [5:0]  angle_comp_second;

  modport source (
    output valid, output cabin_index, output packet_end, output checksum_ok,
    output start_angle, output new_scan, output distance_first,
    output angle_comp_first, output distance_second, output angle_comp_second,
    input ready
  );
  modport sink (
    input valid, input cabin_index, input packet_end, input checksum_ok,
    input start_angle, input new_scan, input distance_first,
    input angle_comp_first, input distance_second, input angle_comp_second,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/lep_parse.sv]
// Byte input register and packet parser state machine with cabin store.
// Depends on lep_pkg, lep_byte_if and the assertion macro header.
`default_nettype none
`include "lidar_express_packet_parser_macros.svh"

module lep_parse #(
  parameter int unsigned CABINS = lep_pkg::CABINS_DEF
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  lep_byte_if.sink        byte_i,
  input  wire             res_free_i,
  output logic            res_valid_o,
  output lep_pkg::result_t res_o
);

  localparam int unsigned CNT_W = (CABINS > 1) ? $clog2(CABINS) : 1;

  typedef enum logic [1:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_ANGLE,
    PH_CABIN
  } phase_e;

  // Input register.
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Parser state.
  phase_e     phase_q, phase_d;
  logic [2:0] pos_q, pos_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0] chk_q, chk_d;
  logic [7:0] xor_q, xor_d;
  logic [15:0] angle_q, angle_d;

  // Cabin store: first four bytes of the current cabin.
  logic [7:0] cab_q [4];

  logic             emits;
  logic             step;
  logic             last;
  logic [7:0]       xor_now;
  logic [CNT_W+3:0] cnt_ext;

  assign emits   = (phase_q == PH_CABIN) && (pos_q == lep_pkg::LAST_POS);
  assign step    = in_valid_q && (!emits || res_free_i);
  assign last    = (cnt_q == CNT_W'(CABINS - 1));
  assign xor_now = xor_q ^ in_byte_q;
  assign cnt_ext = {4'b0000, cnt_q};

  assign byte_i.ready = !in_valid_q || step;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    chk_d   = chk_q;
    xor_d   = xor_q;
    angle_d = angle_q;
    case (phase_q)
      PH_SYNC1: begin
        if (in_byte_q[7:4] == lep_pkg::SYNC1_NIB) begin
          chk_d   = {4'b0000, in_byte_q[3:0]};
          phase_d = PH_SYNC2;
        end
      end
      PH_SYNC2: begin
        if (in_byte_q[7:4] == lep_pkg::SYNC2_NIB) begin
          chk_d   = {in_byte_q[3:0], chk_q[3:0]};
          xor_d   = '0;
          pos_d   = '0;
          cnt_d   = '0;
          phase_d = PH_ANGLE;
        end else begin
          phase_d = PH_SYNC1;
        end
      end
      PH_ANGLE: begin
        xor_d = xor_now;
        if (pos_q == 3'd0) begin
          angle_d = {angle_q[15:8], in_byte_q};
          pos_d   = 3'd1;
        end else begin
          angle_d = {in_byte_q, angle_q[7:0]};
          pos_d   = '0;
          phase_d = PH_CABIN;
        end
      end
      PH_CABIN: begin
        xor_d = xor_now;
        if (pos_q != lep_pkg::LAST_POS) begin
          pos_d = pos_q + 3'd1;
        end else begin
          pos_d = '0;
          if (last) begin
            cnt_d   = '0;
            phase_d = PH_SYNC1;
          end else begin
            cnt_d = CNT_W'(cnt_q + 1'b1);
          end
        end
      end
      default: phase_d = PH_SYNC1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= PH_SYNC1;
      pos_q      <= '0;
      cnt_q      <= '0;
      chk_q      <= '0;
      xor_q      <= '0;
      angle_q    <= '0;
    end else begin
      if (byte_i.ready) begin
        in_valid_q <= byte_i.valid;
      end
      if (step) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        cnt_q   <= cnt_d;
        chk_q   <= chk_d;
        xor_q   <= xor_d;
        angle_q <= angle_d;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.rx_byte;
    end
    if (step && (phase_q == PH_CABIN) && (pos_q != lep_pkg::LAST_POS)) begin
      cab_q[pos_q[1:0]] <= in_byte_q;
    end
  end

  assign res_valid_o = in_valid_q && emits;

  always_comb begin
    res_o.cabin_index       = cnt_ext[3:0];
    res_o.packet_end        = last;
    res_o.checksum_ok       = last && (xor_now == chk_q);
    res_o.start_angle       = angle_q[14:0];
    res_o.new_scan          = angle_q[15];
    res_o.distance_first    = {cab_q[1], cab_q[0][7:2]};
    res_o.angle_comp_first  = {cab_q[0][1:0], in_byte_q[3:0]};
    res_o.distance_second   = {cab_q[3], cab_q[2][7:2]};
    res_o.angle_comp_second = {cab_q[2][1:0], in_byte_q[7:4]};
  end

  `LEP_ASSERT_IMPL(a_pos_range, phase_q == PH_CABIN, pos_q <= lep_pkg::LAST_POS,
                   "cabin byte position out of range")
  `LEP_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CNT_W'(CABINS - 1),
                   "cabin counter beyond packet length")
  `LEP_ASSERT_NEXT(a_end_rehunt, step && emits && last, phase_q == PH_SYNC1,
                   "parser did not return to sync hunt after last cabin")
  `LEP_ASSERT_IMPL(a_chk_only_end, res_valid_o && res_o.checksum_ok, res_o.packet_end,
                   "checksum flag raised before packet end")

endmodule

`default_nettype wire

[rtl/core/lep_out_reg.sv]
// Result register driving the cabin output channel.
// Depends on lep_pkg and lep_cabin_if.
`default_nettype none

module lep_out_reg (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              res_valid_i,
  input  wire lep_pkg::result_t res_i,
  output logic             res_free_o,
  lep_cabin_if.source      cabin_o
);

  logic             valid_q;
  lep_pkg::result_t res_q;
  logic             load;

  // Free when empty or when the held item leaves this cycle.
  assign res_free_o = !valid_q || cabin_o.ready;
  assign load       = res_valid_i && res_free_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_free_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign cabin_o.valid             = valid_q;
  assign cabin_o.cabin_index       = res_q.cabin_index;
  assign cabin_o.packet_end        = res_q.packet_end;
  assign cabin_o.checksum_ok       = res_q.checksum_ok;
  assign cabin_o.start_angle       = res_q.start_angle;
  assign cabin_o.new_scan          = res_q.new_scan;
  assign cabin_o.distance_first    = res_q.distance_first;
  assign cabin_o.angle_comp_first  = res_q.angle_comp_first;
  assign cabin_o.distance_second   = res_q.distance_second;
  assign cabin_o.angle_comp_second = res_q.angle_comp_second;

endmodule

`default_nettype wire

[rtl/core/lidar_express_packet_parser.sv]
// Top level of the express-scan packet parser.
// Depends on lep_pkg, lep_if, lep_parse and lep_out_reg.
// Usage:
//   byte_i  - one received link byte per item (valid/ready). Bytes are taken
//             at one per clock; ready drops only while a finished cabin
//             result cannot move into the output register.
//   cabin_o - one item per completed five-byte cabin: cabin index, start
//             angle and new-scan bit of the packet, two distances and two
//             angle compensations. On the last of CABINS cabins packet_end
//             is high and checksum_ok tells whether the XOR of all bytes
//             after the sync pair matched the checksum in the sync nibbles.
//   Path: a byte is parsed while it sits in the input register; a cabin result
//   is loaded into the output register while its fifth byte sits there.
//   Throughput: one byte per cycle when not stalled, set by the single parser
//   step between the input and result registers.
//   Stall: while cabin_o is stalled, sync, angle and the first four cabin
//   bytes keep flowing; only the fifth byte of the next cabin waits in the
//   input register until the held result is taken.
//   Reset: the parser hunts for the first sync byte, both registers empty.
//   A bad second sync byte is dropped and hunting restarts.
`default_nettype none

module lidar_express_packet_parser #(
  parameter int unsigned CABINS = lep_pkg::CABINS_DEF
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  lep_byte_if.sink     byte_i,
  lep_cabin_if.source  cabin_o
);

  logic             res_valid;
  logic             res_free;
  lep_pkg::result_t res;

  // Parse bytes; hand each finished cabin to the result register.
  lep_parse #(
    .CABINS (CABINS)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Hold the result until the receiver takes it.
  lep_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_free_o  (res_free),
    .cabin_o     (cabin_o)
  );

endmodule

`default_nettype wire
